// ===== hdl/cfl_pkg.sv =====
// Package for the CFL time-step reduction block.
// Holds fixed-point constants and shared types; no dependencies.
package cfl_pkg;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] TENTH_Q = 32'sd6554;
   localparam logic signed [31:0] INV_SQRT3_Q = 32'sd37837;
   localparam logic [16:0] COURANT_RESET = 17'd32768;
   localparam logic [30:0] END_TIME_RESET = 31'd65536;

   // register indexes of the configuration port
   localparam logic CSR_COURANT = 1'b0;
   localparam logic CSR_END_TIME = 1'b1;

   // divider command and status
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;   // magnitude
      logic [63:0] divisor;    // magnitude, nonzero
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [63:0] quotient;
   } div_sts_type;

   // saturate a 66-bit signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) r = S32_MAX;
      else if (v < -66'sh0_8000_0000) r = S32_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== hdl/cfl_divider.sv =====
// Shared unsigned radix-2 restoring divider, one quotient bit per cycle.
// Depends on cfl_pkg.
module cfl_divider
   import cfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[63:0], quo_ff[63]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[63:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done     = done_ff;
   assign sts.busy     = busy_ff;
   assign sts.quotient = quo_ff;

endmodule

// ===== hdl/cfl_time_step_reduce_top.sv =====
// Top level of the CFL time-step reduction block.
// Depends on cfl_pkg and cfl_divider.
// A non-last cell is only reduced and its mass stored. The last cell first runs one
// division for dt, then one division per stored cell, each on the shared
// bit-serial divider. busy is high meanwhile and no new cell is accepted.
// Reset (synchronous, active high) clears grid state, time and registers;
// the mass memory is not cleared. The receiver cannot stall results.
module cfl_time_step_reduce_top
   import cfl_pkg::*;
#(
   parameter int MAX_CELLS = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_left_edge,
   input  logic signed [31:0] req_right_edge,
   input  logic signed [31:0] req_velocity,
   input  logic [30:0]        req_cell_mass,
   input  logic               req_last_cell,
   output logic               rsp_valid,
   output logic [5:0]         rsp_cell_index,
   output logic signed [31:0] rsp_time_step,
   output logic signed [31:0] rsp_step_over_mass,
   output logic signed [31:0] rsp_new_time,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AW = $clog2(MAX_CELLS);
   localparam int CW = $clog2(MAX_CELLS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DT   = 3'd1;
   localparam logic [2:0] ST_DTW  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DIVW = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [16:0] courant_ff;
   logic [30:0] end_time_ff;
   logic [30:0] mass_mem [MAX_CELLS];
   logic [30:0] mass_rd_ff;
   logic [CW-1:0] seen_ff, seen_in;
   logic [CW-1:0] k_ff, k_in;
   logic signed [31:0] minw_ff, minw_in, maxl_ff, maxl_in, maxr_ff, maxr_in;
   logic signed [31:0] prevv_ff, prevv_in, pend_ff, pend_in, time_ff, time_in;
   logic signed [31:0] dt_ff, dt_in;
   logic               neg_ff, neg_in;
   logic [1:0]         grid_cnt_ff, grid_cnt_in;   // saturating count up to 3
   logic signed [31:0] width, jump;
   logic signed [32:0] vdiff;
   logic signed [65:0] wide;
   logic signed [65:0] tsum;
   logic [63:0]        num_mag;
   logic signed [49:0] num;
   logic signed [31:0] dt_raw, dt_clip;
   logic               accept;
   div_cmd_type        dcmd;
   div_sts_type        dsts;
   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [5:0]         rsp_idx_ff, rsp_idx_in;
   logic signed [31:0] rsp_q_ff, rsp_q_in;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         courant_ff  <= COURANT_RESET;
         end_time_ff <= END_TIME_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COURANT:  courant_ff  <= csr_wdata[16:0];
            CSR_END_TIME: end_time_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // mass memory: one write per transfer while fewer than MAX_CELLS are stored, registered read
   always_ff @(posedge clock) begin
      if (accept && (seen_ff < CW'(MAX_CELLS)))
         mass_mem[seen_ff[AW-1:0]] <= req_cell_mass;
      mass_rd_ff <= mass_mem[k_ff[AW-1:0]];
   end

   // per-cell reductions
   always_comb begin
      wide  = 66'(req_right_edge) - 66'(req_left_edge);
      width = sat32(wide);
      vdiff = 33'(req_velocity) - 33'(prevv_ff);
      if (vdiff < 0) vdiff = -vdiff;
      jump  = (vdiff > 33'sh0_7FFF_FFFF) ? S32_MAX : vdiff[31:0];
   end

   assign num = $signed({1'b0, courant_ff}) * minw_ff;
   assign tsum = 66'(dt_raw) + 66'(time_ff);

   always_comb begin
      // quotient magnitude sign-corrected and saturated, dt clipped to end time, numerator magnitude
      if (dsts.quotient > 64'h7FFF_FFFF)
         dt_raw = neg_ff ? ((dsts.quotient > 64'h8000_0000) ? S32_MIN : S32_MIN)
                         : S32_MAX;
      else
         dt_raw = neg_ff ? -$signed(dsts.quotient[31:0]) : $signed(dsts.quotient[31:0]);
      if (tsum > 66'($signed({1'b0, end_time_ff})))
         dt_clip = sat32(66'($signed({1'b0, end_time_ff})) - 66'(time_ff));
      else
         dt_clip = dt_raw;
      num_mag = num[49] ? 64'(-num) : 64'(num);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      k_in        = k_ff;
      minw_in     = minw_ff;
      maxl_in     = maxl_ff;
      maxr_in     = maxr_ff;
      prevv_in    = prevv_ff;
      pend_in     = pend_ff;
      time_in     = time_ff;
      dt_in       = dt_ff;
      neg_in      = neg_ff;
      grid_cnt_in = grid_cnt_ff;
      dcmd        = '0;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_q_in     = rsp_q_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (width < minw_ff) minw_in = width;
               if (grid_cnt_ff == 2'd3) begin
                  if (pend_ff > maxl_ff) maxl_in = pend_ff;
                  if (jump > maxr_ff) maxr_in = jump;
               end else begin
                  grid_cnt_in = grid_cnt_ff + 2'd1;
               end
               pend_in  = jump;
               prevv_in = req_velocity;
               if (seen_ff < CW'(MAX_CELLS)) seen_in = seen_ff + CW'(1);
               if (req_last_cell) state_in = ST_DT;
            end
         end
         ST_DT: begin
            dcmd.start    = 1'b1;
            dcmd.dividend = num_mag;
            dcmd.divisor  = 64'(INV_SQRT3_Q) + 64'(maxl_ff) + 64'(maxr_ff);
            neg_in        = num[49];
            state_in      = ST_DTW;
         end
         ST_DTW: begin
            if (dsts.done) begin
               dt_in    = dt_clip;
               time_in  = sat32(66'(dt_clip) + 66'(time_ff));
               k_in     = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            // memory read in flight
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dcmd.start    = 1'b1;
            dcmd.dividend = dt_ff[31] ? 64'(-64'(signed'(dt_ff)) <<< 16)
                                      : 64'(64'(signed'(dt_ff)) <<< 16);
            dcmd.divisor  = (mass_rd_ff == '0) ? 64'd1 : 64'(mass_rd_ff);
            neg_in        = dt_ff[31];
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (dsts.done) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 6'(k_ff);
               if (mass_rd_ff == '0)
                  rsp_q_in = dt_ff[31] ? S32_MIN : S32_MAX;
               else
                  rsp_q_in = dt_raw;
               if (k_ff + CW'(1) == seen_ff) begin
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
                  seen_in     = '0;
                  minw_in     = S32_MAX;
                  maxl_in     = TENTH_Q;
                  maxr_in     = TENTH_Q;
                  prevv_in    = '0;
                  pend_in     = '0;
                  grid_cnt_in = '0;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         k_ff         <= '0;
         minw_ff      <= S32_MAX;
         maxl_ff      <= TENTH_Q;
         maxr_ff      <= TENTH_Q;
         prevv_ff     <= '0;
         pend_ff      <= '0;
         time_ff      <= '0;
         grid_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         k_ff         <= k_in;
         minw_ff      <= minw_in;
         maxl_ff      <= maxl_in;
         maxr_ff      <= maxr_in;
         prevv_ff     <= prevv_in;
         pend_ff      <= pend_in;
         time_ff      <= time_in;
         grid_cnt_ff  <= grid_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      dt_ff      <= dt_in;
      neg_ff     <= neg_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_q_ff   <= rsp_q_in;
   end

   cfl_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .sts   (dsts)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_index     = rsp_idx_ff;
   assign rsp_time_step      = dt_ff;
   assign rsp_step_over_mass = rsp_q_ff;
   assign rsp_new_time       = time_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule

// ===== hdl/cfl_time_step_reduce_checker.sv =====
// Port-level checker for the CFL time-step reduction block, bound to the top.
// Depends on cfl_time_step_reduce_top's ports only.
module cfl_time_step_reduce_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_time_step,
   input logic        rsp_last_result
);

   // results appear only while a grid is being emitted
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("result outside busy window");

   // back-to-back results are impossible: each needs a division
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results too close");

   // the final result ends the busy window
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !busy)
      else $error("busy after final result");

   // time step is constant across one grid's results
   a_dt_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> $stable(rsp_time_step))
      else $error("time step changed within grid");

endmodule

bind cfl_time_step_reduce_top cfl_time_step_reduce_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_time_step   (rsp_time_step),
   .rsp_last_result (rsp_last_result)
);

// ===== bench/cfl_time_step_reduce_top_tb.sv =====
// Testbench for cfl_time_step_reduce_top: streams grids of cells and checks every
// per-cell result field against a built-in predictor. Depends on cfl_pkg and the block.
`timescale 1ns / 1ps

module cfl_time_step_reduce_top_tb;
   import cfl_pkg::*;

   localparam int NCELLS = 32;
   localparam int CYCLE_LIMIT = 2000000;
   localparam longint LMAX = 64'sh7FFF_FFFF;
   localparam longint LMIN = -64'sh8000_0000;

   typedef struct {
      logic signed [31:0] left_edge;
      logic signed [31:0] right_edge;
      logic signed [31:0] velocity;
      logic [30:0]        cell_mass;
      logic               last_cell;
   } cell_type;

   typedef struct {
      logic [5:0]         cell_index;
      logic signed [31:0] time_step;
      logic signed [31:0] step_over_mass;
      logic signed [31:0] new_time;
      logic               last_result;
   } ratio_type;

   logic clock, reset, start, busy;
   logic signed [31:0] req_left_edge, req_right_edge, req_velocity;
   logic [30:0] req_cell_mass;
   logic req_last_cell;
   logic rsp_valid;
   logic [5:0] rsp_cell_index;
   logic signed [31:0] rsp_time_step, rsp_step_over_mass, rsp_new_time;
   logic rsp_last_result;
   logic csr_valid, csr_ready, csr_index;
   logic [31:0] csr_wdata;

   cfl_time_step_reduce_top #(.MAX_CELLS(NCELLS)) i_dut (.*);

   cell_type  cells_to_send[$];
   ratio_type ratios_due[$];
   int     errors = 0;
   int     cycles = 0;
   int     gap_cnt = 0;
   int     burst_cnt = 1;

   // predictor state
   int unsigned courant_q = COURANT_RESET;
   int unsigned end_time_q = END_TIME_RESET;
   logic [30:0] grid_mass[NCELLS];
   int     grid_count = 0;
   longint min_width = LMAX, max_left = TENTH_Q, max_right = TENTH_Q;
   longint prev_vel = 0, held_left = 0, sim_time = 0;

   function automatic longint clamp32(longint v);
      if (v > LMAX) return LMAX;
      if (v < LMIN) return LMIN;
      return v;
   endfunction

   // reduce one cell; on the last cell queue a ratio per stored cell
   function automatic void reduce_cell(cell_type c);
      longint w, jump, denom, dt, nt, q;
      ratio_type r;
      w = clamp32(longint'(c.right_edge) - longint'(c.left_edge));
      if (w < min_width) min_width = w;
      jump = longint'(c.velocity) - prev_vel;
      if (jump < 0) jump = -jump;
      if (jump > LMAX) jump = LMAX;
      // previous cell is interior once three cells precede this one
      if (grid_count >= 3) begin
         if (held_left > max_left) max_left = held_left;
         if (jump > max_right) max_right = jump;
      end
      held_left = jump;
      prev_vel = c.velocity;
      if (grid_count < NCELLS) begin
         grid_mass[grid_count] = c.cell_mass;
         grid_count++;
      end
      if (!c.last_cell) return;
      denom = longint'(INV_SQRT3_Q) + max_left + max_right;
      dt = clamp32((longint'(courant_q) * min_width) / denom);
      if (dt + sim_time > longint'(end_time_q)) dt = clamp32(longint'(end_time_q) - sim_time);
      nt = clamp32(sim_time + dt);
      sim_time = nt;
      for (int k = 0; k < grid_count; k++) begin
         if (grid_mass[k] == 0) q = (dt >= 0) ? LMAX : LMIN;
         else q = clamp32((dt * 65536) / longint'(grid_mass[k]));
         r.cell_index = k[5:0];
         r.time_step = dt[31:0];
         r.step_over_mass = q[31:0];
         r.new_time = nt[31:0];
         r.last_result = (k + 1 == grid_count);
         ratios_due.push_back(r);
      end
      grid_count = 0;
      min_width = LMAX;
      max_left = TENTH_Q;
      max_right = TENTH_Q;
      prev_vel = 0;
      held_left = 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: bursts of transfers with random gaps
   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         start <= 1'b0;
         req_left_edge <= '0;
         req_right_edge <= '0;
         req_velocity <= '0;
         req_cell_mass <= '0;
         req_last_cell <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            reduce_cell(cells_to_send.pop_front());
            burst_cnt--;
            if (burst_cnt <= 0) begin
               burst_cnt = $urandom_range(1, 12);
               gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (start && !taken) begin
            start <= 1'b1;
         end else if (gap_cnt > 0) begin
            gap_cnt--;
            start <= 1'b0;
         end else if (cells_to_send.size() > 0) begin
            start <= 1'b1;
            req_left_edge <= cells_to_send[0].left_edge;
            req_right_edge <= cells_to_send[0].right_edge;
            req_velocity <= cells_to_send[0].velocity;
            req_cell_mass <= cells_to_send[0].cell_mass;
            req_last_cell <= cells_to_send[0].last_cell;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: each strobed result against the oldest expectation
   always @(posedge clock) begin
      ratio_type e;
      if (!reset && rsp_valid) begin
         if (ratios_due.size() == 0) begin
            $display("%0t: unexpected result index %0d", $time, rsp_cell_index);
            errors++;
         end else begin
            e = ratios_due.pop_front();
            if (rsp_cell_index !== e.cell_index) begin
               $display("%0t: cell_index exp %0d got %0d", $time, e.cell_index, rsp_cell_index);
               errors++;
            end
            if (rsp_time_step !== e.time_step) begin
               $display("%0t: time_step exp %0d got %0d", $time, e.time_step, rsp_time_step);
               errors++;
            end
            if (rsp_step_over_mass !== e.step_over_mass) begin
               $display("%0t: step_over_mass exp %0d got %0d", $time, e.step_over_mass,
                        rsp_step_over_mass);
               errors++;
            end
            if (rsp_new_time !== e.new_time) begin
               $display("%0t: new_time exp %0d got %0d", $time, e.new_time, rsp_new_time);
               errors++;
            end
            if (rsp_last_result !== e.last_result) begin
               $display("%0t: last_result exp %0b got %0b", $time, e.last_result,
                        rsp_last_result);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cfl_time_step_reduce_top_tb: errors");
         $finish;
      end
   end

   task automatic write_csr(logic idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_COURANT) courant_q = data[16:0];
      else end_time_q = data[30:0];
      csr_valid <= 1'b0;
   endtask

   task automatic push_cell(logic [31:0] l, logic [31:0] r, logic [31:0] v, logic [30:0] m,
                            logic last);
      cell_type c;
      c.left_edge = l;
      c.right_edge = r;
      c.velocity = v;
      c.cell_mass = m;
      c.last_cell = last;
      cells_to_send.push_back(c);
   endtask

   // one grid with random content, mostly well-formed geometry
   task automatic push_grid(int n);
      logic [31:0] l, w, v;
      logic [30:0] m;
      for (int i = 0; i < n; i++) begin
         l = $urandom_range(0, 7) == 0 ? $urandom : i * 65536 - $urandom_range(0, 65535);
         w = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 4 * 65536);
         v = $urandom_range(0, 6) == 0 ? $urandom
                                       : $urandom_range(0, 8 * 65536) - 4 * 65536;
         m = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32'h7FFF_FFFF)
                                       : $urandom_range(1, 4 * 65536);
         push_cell(l, l + w, v, m, i == n - 1);
      end
   endtask

   // wait for the block to drain, then let it settle
   task automatic drain();
      @(posedge clock);
      while (cells_to_send.size() > 0 || start || busy || ratios_due.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      int sent;
      int n;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_COURANT;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: saturating width, short grids, extreme jumps, negative width
      push_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      push_cell(0, 65536, 100, 65536, 1'b0);
      push_cell(65536, 131072, -100, 1, 1'b0);
      push_cell(131072, 196608, 7, 31'h7FFF_FFFF, 1'b1);
      for (int i = 0; i < 6; i++)
         push_cell(i * 65536, i * 65536 + 40000, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                   i[0] ? 31'd1 : 31'h7FFF_FFFF, i == 5);
      for (int i = 0; i < 4; i++)
         push_cell(i * 65536 + 65536, i * 65536, i * 3000, 31'd1, i == 3);
      drain();

      // phases over register settings, extremes first
      for (int p = 0; p < 10; p++) begin
         case (p)
            0: write_csr(CSR_COURANT, 32'd65536);
            1: write_csr(CSR_COURANT, 32'd0);
            default: write_csr(CSR_COURANT, $urandom);
         endcase
         case (p)
            0: write_csr(CSR_END_TIME, 32'h7FFF_FFFF);
            2: write_csr(CSR_END_TIME, 32'd0);
            3: write_csr(CSR_END_TIME, 32'(sim_time + $urandom_range(0, 65536)));
            default: write_csr(CSR_END_TIME, $urandom);
         endcase
         sent = 0;
         while (sent < 39) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
            push_grid(n);
            sent += n;
         end
         drain();
      end

      if (errors == 0) begin
         $display("cfl_time_step_reduce_top_tb: clean");
      end else begin
         $display("cfl_time_step_reduce_top_tb: errors");
      end
      $finish;
   end

endmodule
